// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro is empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising edge of clk outside reset.
`define CIA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that an expression is never true at a rising edge of clk outside reset.
`define CIA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define CIA_ASSERT(lbl, clk, rstn, prop, msg)
`define CIA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- sv/cia402_pkg.sv -----
package cia402_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [1:0] OP_CYCLE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [1:0] REG_AUTO_FAULT_RESET = 2'd0;
	localparam logic [1:0] REG_STARTUP_FAULT_RESET = 2'd1;
	localparam logic [1:0] REG_AUTO_TRANSITIONS = 2'd2;
	localparam logic [1:0] REG_QUICK_STOP_SUPPORTED = 2'd3;

	localparam logic [3:0] ST_START = 4'd0;
	localparam logic [3:0] ST_NOT_READY = 4'd1;
	localparam logic [3:0] ST_SO_DISABLED = 4'd2;
	localparam logic [3:0] ST_READY = 4'd3;
	localparam logic [3:0] ST_SWITCHED_ON = 4'd4;
	localparam logic [3:0] ST_ENABLED = 4'd5;
	localparam logic [3:0] ST_QUICK_STOP = 4'd6;
	localparam logic [3:0] ST_FAULT_REACTION = 4'd7;
	localparam logic [3:0] ST_FAULT = 4'd8;
	localparam logic [3:0] ST_UNDEFINED = 4'd9;

	localparam logic [15:0] CW_QUICK_STOP = 16'h000B;
	localparam logic [15:0] CW_DISABLE_OP = 16'h0007;
	localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
	localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

	localparam logic [15:0] SW_MASK_A = 16'h004F;
	localparam logic [15:0] SW_MASK_B = 16'h006F;

	function automatic logic [3:0] decode_status(input logic [15:0] sw);
		logic [15:0] a;
		logic [15:0] b;
		logic [3:0] st;
		a = sw & SW_MASK_A;
		b = sw & SW_MASK_B;
		if (a == 16'h0000) st = ST_NOT_READY;
		else if (a == 16'h0040) st = ST_SO_DISABLED;
		else if (b == 16'h0021) st = ST_READY;
		else if (b == 16'h0023) st = ST_SWITCHED_ON;
		else if (b == 16'h0027) st = ST_ENABLED;
		else if (b == 16'h0007) st = ST_QUICK_STOP;
		else if (a == 16'h000F) st = ST_FAULT_REACTION;
		else if (a == 16'h0008) st = ST_FAULT;
		else st = ST_UNDEFINED;
		return st;
	endfunction

	function automatic logic is_fault(input logic [3:0] s);
		return (s == ST_FAULT) || (s == ST_FAULT_REACTION);
	endfunction

endpackage

// ----- sv/cia402_drive_state_sequencer.sv -----
// Channel   Handshake                 Payload
// input     in_valid / in_ready       op, sts_word, err_code, cmd_word,
//                                     reset_request, operational, hold_cycles
// result    out_valid / out_ready     ctrl_word, drive_state_code, fault_code,
//                                     fault_status, hold_commands, wind_down_done
// config    cfg_wr_en                 cfg_index, cfg_data
//
// One item per cycle is accepted while the result is not stalled; its result passes the input
// register, the decode and the result register before it reaches the outputs.
// Reset puts the drive state at start and clears all latches, counters, configuration
// registers and valid flags.
// A stalled result holds the result register; the input register takes one more item.
`include "assert_macros.svh"

module cia402_drive_state_sequencer #(
	parameter int COUNT_WIDTH = cia402_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] sts_word,
	input  logic [15:0] err_code,
	input  logic [15:0] cmd_word,
	input  logic        reset_request,
	input  logic        operational,
	input  logic [31:0] hold_cycles,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] ctrl_word,
	output logic [3:0]  drive_state_code,
	output logic [15:0] fault_code,
	output logic [15:0] fault_status,
	output logic        hold_commands,
	output logic        wind_down_done
);

	logic auto_fault_reset_q;
	logic startup_fault_reset_q;
	logic auto_transitions_q;
	logic quick_stop_supported_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] sts_word_s1;
	logic [15:0] err_code_s1;
	logic [15:0] command_s1;
	logic        reset_request_s1;
	logic        operational_s1;
	logic [31:0] hold_cycles_s1;

	logic [3:0]             drive_state_q;
	logic [15:0]            fault_code_q;
	logic [15:0]            fault_status_q;
	logic                   enabled_reached_q;
	logic                   reset_pending_q;
	logic                   reset_request_prev_q;
	logic                   wind_down_active_q;
	logic                   wind_down_finished_q;
	logic [COUNT_WIDTH-1:0] wind_down_count_q;
	logic [COUNT_WIDTH-1:0] hold_limit_q;

	logic [3:0]             drive_state_d;
	logic [15:0]            fault_code_d;
	logic [15:0]            fault_status_d;
	logic                   enabled_reached_d;
	logic                   reset_pending_d;
	logic                   reset_request_prev_d;
	logic                   wind_down_active_d;
	logic                   wind_down_finished_d;
	logic [COUNT_WIDTH-1:0] wind_down_count_d;
	logic [COUNT_WIDTH-1:0] hold_limit_d;
	logic [15:0]            cw_d;
	logic                   hold_cmds_d;

	logic                   advance;
	logic [31:0]            half_hold;
	logic                   half_sat;
	logic [COUNT_WIDTH-1:0] hold_lim_sat;
	logic                   pending_now;
	logic                   boot_clear;
	logic [15:0]            bring_up;

	logic                   out_valid_q;
	logic [15:0]            ctrl_word_q;
	logic [3:0]             drive_state_code_q;
	logic [15:0]            fault_code_out_q;
	logic [15:0]            fault_status_out_q;
	logic                   hold_commands_q;
	logic                   wind_down_done_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_fault_reset_q <= 1'b0;
			startup_fault_reset_q <= 1'b0;
			auto_transitions_q <= 1'b0;
			quick_stop_supported_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cia402_pkg::REG_AUTO_FAULT_RESET: auto_fault_reset_q <= cfg_data;
				cia402_pkg::REG_STARTUP_FAULT_RESET: startup_fault_reset_q <= cfg_data;
				cia402_pkg::REG_AUTO_TRANSITIONS: auto_transitions_q <= cfg_data;
				cia402_pkg::REG_QUICK_STOP_SUPPORTED: quick_stop_supported_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			sts_word_s1 <= sts_word;
			err_code_s1 <= err_code;
			command_s1 <= cmd_word;
			reset_request_s1 <= reset_request;
			operational_s1 <= operational;
			hold_cycles_s1 <= hold_cycles;
		end
	end

	assign half_hold    = {1'b0, hold_cycles_s1[31:1]};
	assign half_sat     = |(half_hold >> COUNT_WIDTH);
	assign hold_lim_sat = half_sat ? {COUNT_WIDTH{1'b1}} : half_hold[COUNT_WIDTH-1:0];

	assign pending_now = reset_pending_q || (reset_request_s1 && !reset_request_prev_q);
	assign boot_clear  = startup_fault_reset_q && !enabled_reached_q;

	always_comb begin
		case (drive_state_q)
			cia402_pkg::ST_SO_DISABLED: bring_up = (command_s1 & 16'h007E) | 16'h0006;
			cia402_pkg::ST_READY: bring_up = (command_s1 & 16'h0077) | 16'h0007;
			cia402_pkg::ST_SWITCHED_ON: bring_up = (command_s1 & 16'h007F) | 16'h000F;
			cia402_pkg::ST_QUICK_STOP: bring_up = (command_s1 & 16'h007F) | 16'h000F;
			cia402_pkg::ST_FAULT: begin
				if (auto_fault_reset_q || pending_now || boot_clear) begin
					bring_up = (command_s1 & 16'h00FF) | cia402_pkg::CW_FAULT_RESET;
				end else begin
					bring_up = command_s1;
				end
			end
			default: bring_up = command_s1;
		endcase
	end

	always_comb begin
		drive_state_d = drive_state_q;
		fault_code_d = fault_code_q;
		fault_status_d = fault_status_q;
		enabled_reached_d = enabled_reached_q;
		reset_pending_d = reset_pending_q;
		reset_request_prev_d = reset_request_prev_q;
		wind_down_active_d = wind_down_active_q;
		wind_down_finished_d = wind_down_finished_q;
		wind_down_count_d = wind_down_count_q;
		hold_limit_d = hold_limit_q;
		cw_d = 16'h0000;
		hold_cmds_d = wind_down_active_q || (drive_state_q != cia402_pkg::ST_ENABLED);

		unique case (op_s1)
			cia402_pkg::OP_START: begin
				wind_down_active_d = 1'b1;
				wind_down_count_d = '0;
				wind_down_finished_d = 1'b0;
				hold_limit_d = hold_lim_sat;
			end
			cia402_pkg::OP_RESET: begin
				if (wind_down_active_q) begin
					wind_down_active_d = 1'b0;
					wind_down_finished_d = 1'b1;
					wind_down_count_d = '0;
					hold_limit_d = '0;
				end
			end
			default: begin
				if (operational_s1 && wind_down_active_q) begin
					case (drive_state_q)
						cia402_pkg::ST_ENABLED: begin
							cw_d = quick_stop_supported_q ? cia402_pkg::CW_QUICK_STOP
								: cia402_pkg::CW_DISABLE_OP;
						end
						cia402_pkg::ST_QUICK_STOP: begin
							if (quick_stop_supported_q && (wind_down_count_q < hold_limit_q)) begin
								cw_d = cia402_pkg::CW_QUICK_STOP;
							end else begin
								cw_d = cia402_pkg::CW_DISABLE_VOLTAGE;
							end
						end
						cia402_pkg::ST_FAULT_REACTION: cw_d = cia402_pkg::CW_DISABLE_VOLTAGE;
						default: begin
							cw_d = cia402_pkg::CW_DISABLE_VOLTAGE;
							wind_down_finished_d = 1'b1;
						end
					endcase
				end else if (operational_s1) begin
					reset_request_prev_d = reset_request_s1;
					reset_pending_d = pending_now;
					if (auto_transitions_q) begin
						cw_d = bring_up;
						if ((drive_state_q == cia402_pkg::ST_FAULT)
							&& (auto_fault_reset_q || pending_now || boot_clear)) begin
							reset_pending_d = 1'b0;
						end
					end else begin
						cw_d = command_s1;
					end
				end else begin
					cw_d = command_s1;
				end

				drive_state_d = cia402_pkg::decode_status(sts_word_s1);
				if (cia402_pkg::is_fault(drive_state_d)) begin
					if (!cia402_pkg::is_fault(drive_state_q)) begin
						fault_code_d = err_code_s1;
						fault_status_d = sts_word_s1;
					end else if ((fault_code_q == 16'h0000) && (err_code_s1 != 16'h0000)) begin
						fault_code_d = err_code_s1;
					end
				end
				if (drive_state_d == cia402_pkg::ST_ENABLED) begin
					enabled_reached_d = 1'b1;
				end
				if (wind_down_active_q && !wind_down_finished_d
					&& (wind_down_count_q != {COUNT_WIDTH{1'b1}})) begin
					wind_down_count_d = wind_down_count_q + 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_state_q <= cia402_pkg::ST_START;
			fault_code_q <= '0;
			fault_status_q <= '0;
			enabled_reached_q <= 1'b0;
			reset_pending_q <= 1'b0;
			reset_request_prev_q <= 1'b0;
			wind_down_active_q <= 1'b0;
			wind_down_finished_q <= 1'b0;
			wind_down_count_q <= '0;
			hold_limit_q <= '0;
		end else if (advance) begin
			drive_state_q <= drive_state_d;
			fault_code_q <= fault_code_d;
			fault_status_q <= fault_status_d;
			enabled_reached_q <= enabled_reached_d;
			reset_pending_q <= reset_pending_d;
			reset_request_prev_q <= reset_request_prev_d;
			wind_down_active_q <= wind_down_active_d;
			wind_down_finished_q <= wind_down_finished_d;
			wind_down_count_q <= wind_down_count_d;
			hold_limit_q <= hold_limit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_word_q <= cw_d;
			drive_state_code_q <= drive_state_d;
			fault_code_out_q <= fault_code_d;
			fault_status_out_q <= fault_status_d;
			hold_commands_q <= hold_cmds_d;
			wind_down_done_q <= wind_down_finished_d || !operational_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign ctrl_word        = ctrl_word_q;
	assign drive_state_code = drive_state_code_q;
	assign fault_code       = fault_code_out_q;
	assign fault_status     = fault_status_out_q;
	assign hold_commands    = hold_commands_q;
	assign wind_down_done   = wind_down_done_q;

	`CIA_ASSERT(a_start_word_zero, clk, arst_n, advance && (op_s1 == cia402_pkg::OP_START) |=> ctrl_word == 16'h0000, "start item must send a zero control word")
	`CIA_ASSERT(a_start_not_done, clk, arst_n, advance && (op_s1 == cia402_pkg::OP_START) && operational_s1 |=> !wind_down_done, "wind-down must not be done right after start")
	`CIA_ASSERT_NEVER(a_ready_low_cause, clk, arst_n, !in_ready && !(valid_s1 && out_valid_q && !out_ready), "input stalled without a full pipeline")

endmodule
